[rtl/tphp_pkg.sv]
// ----------------------------------------------------------------------------
// tphp_pkg: shared types and constants for the text packet header parser
// Phase and field-position codes, token kinds, error codes, byte classes.
// ----------------------------------------------------------------------------
package tphp_pkg;

	typedef enum logic [1:0] {
		PH_FIRST = 2'd0,
		PH_HEAD  = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		FP_PSTART = 4'd0,
		FP_PREST  = 4'd1,
		FP_MSTART = 4'd2,
		FP_MREST  = 4'd3,
		FP_NSTART = 4'd4,
		FP_NREST  = 4'd5,
		FP_SKIP   = 4'd6,
		FP_VDIG   = 4'd7,
		FP_VTAIL  = 4'd8
	} fpos_t;

	typedef logic [2:0] kind_t;
	localparam kind_t KIND_DELIM  = 3'd0;
	localparam kind_t KIND_PROTO  = 3'd1;
	localparam kind_t KIND_METHOD = 3'd2;
	localparam kind_t KIND_NAME   = 3'd3;
	localparam kind_t KIND_VALUE  = 3'd4;
	localparam kind_t KIND_BODY   = 3'd5;

	typedef logic [3:0] err_t;
	localparam err_t ERR_NONE         = 4'd0;
	localparam err_t ERR_EMPTY_FIRST  = 4'd1;
	localparam err_t ERR_PROTO_FIRST  = 4'd2;
	localparam err_t ERR_PROTO_CHAR   = 4'd3;
	localparam err_t ERR_METHOD_FIRST = 4'd4;
	localparam err_t ERR_METHOD_CHAR  = 4'd5;
	localparam err_t ERR_NAME_FIRST   = 4'd6;
	localparam err_t ERR_NAME_CHAR    = 4'd7;
	localparam err_t ERR_NO_VALUE     = 4'd8;
	localparam err_t ERR_VALUE_CHAR   = 4'd9;
	localparam err_t ERR_LEN_REPEAT   = 4'd10;
	localparam err_t ERR_LEN_NONPOS   = 4'd11;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] VAL_LO   = 8'd32;
	localparam logic [7:0] VAL_HI   = 8'd126;

	// length of the "content-length" key
	localparam logic [3:0] KEY_LEN = 4'd14;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= 8'h61) && (c <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_value(input logic [7:0] c);
		return (c >= VAL_LO) && (c < VAL_HI);
	endfunction

	// lower-case key "content-length", one character per index
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h63; // c
			4'd1:    ch = 8'h6F; // o
			4'd2:    ch = 8'h6E; // n
			4'd3:    ch = 8'h74; // t
			4'd4:    ch = 8'h65; // e
			4'd5:    ch = 8'h6E; // n
			4'd6:    ch = 8'h74; // t
			4'd7:    ch = 8'h2D; // -
			4'd8:    ch = 8'h6C; // l
			4'd9:    ch = 8'h65; // e
			4'd10:   ch = 8'h6E; // n
			4'd11:   ch = 8'h67; // g
			4'd12:   ch = 8'h74; // t
			4'd13:   ch = 8'h68; // h
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

[rtl/tphp_digit_acc.sv]
// ----------------------------------------------------------------------------
// tphp_digit_acc: saturating decimal accumulate step
// Computes acc * 10 + digit, clamped to the all-ones value of the width.
// ----------------------------------------------------------------------------
module tphp_digit_acc #(
	parameter int LENGTH_BITS = 32
) (
	input  logic [LENGTH_BITS-1:0] acc,
	input  logic [3:0]             digit,
	output logic [LENGTH_BITS-1:0] acc_next
);

	logic [LENGTH_BITS+3:0] sum;

	// times ten as two shifts and an add
	assign sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
		+ {{LENGTH_BITS{1'b0}}, digit};

	assign acc_next = (sum[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
		? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];

endmodule

[rtl/text_packet_header_parser.sv]
// ----------------------------------------------------------------------------
// text_packet_header_parser: byte-wise parser for text packet headers
// Checks the first line and header lines, picks up content-length and
// tags every byte (including body bytes) with its token kind and errors.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_ready  | data_byte
//  out     | out_valid/out_ready| echo_byte, token_kind, token_start,
//          |                    | error_code, error_seen, line_end,
//          |                    | packet_end, body_length
//
//  One beat in gives exactly one beat out. Throughput is one byte per cycle
//  while out does not stall. A byte passes the input register, then parse
//  logic into the result register. The parse state updates when a byte moves
//  from the input register into the result register, so it always sees the
//  previous byte. arst_n clears all parse state to the start of a packet.
//  A stall on out holds the result register and then the input register;
//  in_ready drops only when both are full.
// ----------------------------------------------------------------------------
module text_packet_header_parser
	import tphp_pkg::*;
#(
	parameter int LENGTH_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             data_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             echo_byte,
	output logic [2:0]             token_kind,
	output logic                   token_start,
	output logic [3:0]             error_code,
	output logic                   error_seen,
	output logic                   line_end,
	output logic                   packet_end,
	output logic [LENGTH_BITS-1:0] body_length
);

	// ---------------- input register ----------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	// move the held byte through when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	// ---------------- parse state ----------------
	phase_t                 phase_q, phase_n;
	fpos_t                  fpos_q, fpos_n;
	logic                   discard_q, discard_n;
	logic [3:0]             midx_q, midx_n;
	logic                   mok_q, mok_n;
	logic [LENGTH_BITS-1:0] acc_q, acc_n;
	logic                   neg_q, neg_n;
	logic [LENGTH_BITS-1:0] clen_q, clen_n;
	logic [LENGTH_BITS-1:0] remain_q, remain_n;
	logic                   sticky_q, sticky_n;

	// result of the current byte
	kind_t      kind;
	logic       start;
	err_t       err;
	logic       le;
	logic       pe;

	logic [7:0]             c;
	logic [7:0]             lc;
	logic                   key_hit;
	logic [LENGTH_BITS-1:0] acc_digit;
	logic [LENGTH_BITS-1:0] remain_dec;
	logic                   name_char;
	logic                   tok_char;

	assign c         = byte_s1;
	assign lc        = is_upper(c) ? (c + 8'd32) : c;
	assign key_hit   = (midx_q < KEY_LEN) && (lc == key_char(midx_q));
	assign name_char = is_upper(c) || is_lower(c) || is_digit(c)
		|| (c == CH_UNDER) || (c == CH_DASH);
	assign tok_char  = is_upper(c) || is_digit(c) || (c == CH_UNDER);
	assign remain_dec = (remain_q != '0) ? (remain_q - 1'b1) : remain_q;

	tphp_digit_acc #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_digit_acc (
		.acc      (acc_q),
		.digit    (c[3:0]),
		.acc_next (acc_digit)
	);

	always_comb begin
		phase_n   = phase_q;
		fpos_n    = fpos_q;
		discard_n = discard_q;
		midx_n    = midx_q;
		mok_n     = mok_q;
		acc_n     = acc_q;
		neg_n     = neg_q;
		clen_n    = clen_q;
		remain_n  = remain_q;
		kind      = KIND_DELIM;
		start     = 1'b0;
		err       = ERR_NONE;
		le        = 1'b0;
		pe        = 1'b0;

		case (phase_q)
			PH_BODY: begin
				// raw body byte; CR and LF count as data
				kind     = KIND_BODY;
				start    = (remain_q == clen_q);
				remain_n = remain_dec;
				pe       = (remain_dec == '0);
			end
			default: begin
				if (c == CH_CR) begin
					// drop
				end else if (c == CH_LF) begin
					le = 1'b1;
					if (!discard_q) begin
						if (phase_q == PH_FIRST) begin
							case (fpos_q)
								FP_PREST:  err = ERR_PROTO_CHAR;
								FP_MSTART: err = ERR_METHOD_FIRST;
								FP_MREST:  phase_n = PH_HEAD;
								default:   err = ERR_EMPTY_FIRST;
							endcase
						end else begin
							case (fpos_q)
								FP_NSTART: begin
									// empty line closes the headers
									if (clen_q != '0) begin
										phase_n  = PH_BODY;
										remain_n = clen_q;
									end else begin
										pe = 1'b1;
									end
								end
								FP_NREST: err = ERR_NAME_CHAR;
								FP_SKIP:  err = ERR_NO_VALUE;
								FP_VDIG, FP_VTAIL: begin
									if (mok_q) begin
										if (clen_q != '0) begin
											err = ERR_LEN_REPEAT;
										end else if (neg_q || (acc_q == '0)) begin
											err = ERR_LEN_NONPOS;
										end else begin
											clen_n = acc_q;
										end
									end
								end
								default: ;
							endcase
						end
					end
					if (!pe && (phase_n != PH_BODY)) begin
						fpos_n    = (phase_n == PH_FIRST) ? FP_PSTART : FP_NSTART;
						discard_n = 1'b0;
						midx_n    = '0;
						mok_n     = 1'b1;
						acc_n     = '0;
						neg_n     = 1'b0;
					end
				end else if (!discard_q) begin
					case (fpos_q)
						FP_PSTART: begin
							if (is_upper(c)) begin
								kind   = KIND_PROTO;
								start  = 1'b1;
								fpos_n = FP_PREST;
							end else begin
								err = ERR_PROTO_FIRST;
							end
						end
						FP_PREST: begin
							if (c == CH_SPACE) begin
								fpos_n = FP_MSTART;
							end else if (tok_char) begin
								kind = KIND_PROTO;
							end else begin
								err = ERR_PROTO_CHAR;
							end
						end
						FP_MSTART: begin
							if (is_upper(c)) begin
								kind   = KIND_METHOD;
								start  = 1'b1;
								fpos_n = FP_MREST;
							end else begin
								err = ERR_METHOD_FIRST;
							end
						end
						FP_MREST: begin
							if (tok_char) begin
								kind = KIND_METHOD;
							end else begin
								err = ERR_METHOD_CHAR;
							end
						end
						FP_NSTART: begin
							if (is_upper(c) || is_lower(c)) begin
								kind   = KIND_NAME;
								start  = 1'b1;
								fpos_n = FP_NREST;
								if (mok_q) begin
									if (key_hit) begin
										midx_n = midx_q + 4'd1;
									end else begin
										mok_n = 1'b0;
									end
								end
							end else begin
								err = ERR_NAME_FIRST;
							end
						end
						FP_NREST: begin
							if (c == CH_COLON) begin
								// name matches only if the whole key was seen
								mok_n  = mok_q && (midx_q == KEY_LEN);
								fpos_n = FP_SKIP;
							end else if (name_char) begin
								kind = KIND_NAME;
								if (mok_q) begin
									if (key_hit) begin
										midx_n = midx_q + 4'd1;
									end else begin
										mok_n = 1'b0;
									end
								end
							end else begin
								err = ERR_NAME_CHAR;
							end
						end
						FP_SKIP: begin
							if (c == CH_SPACE) begin
								// skip leading spaces
							end else if (!is_value(c)) begin
								err = ERR_VALUE_CHAR;
							end else begin
								kind   = KIND_VALUE;
								start  = 1'b1;
								fpos_n = FP_VDIG;
								if (c == CH_DASH) begin
									neg_n = 1'b1;
								end else if (c == CH_PLUS) begin
									// sign only
								end else if (is_digit(c)) begin
									acc_n = acc_digit;
								end else begin
									fpos_n = FP_VTAIL;
								end
							end
						end
						FP_VDIG, FP_VTAIL: begin
							if (!is_value(c)) begin
								err = ERR_VALUE_CHAR;
							end else begin
								kind = KIND_VALUE;
								if ((fpos_q == FP_VDIG) && is_digit(c)) begin
									acc_n = acc_digit;
								end else begin
									fpos_n = FP_VTAIL;
								end
							end
						end
						default: ;
					endcase
					if (err != ERR_NONE) begin
						discard_n = 1'b1;
					end
				end
			end
		endcase

		sticky_n = sticky_q || (err != ERR_NONE);
	end

	// result fields reflect the packet before any end-of-packet restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FIRST;
			fpos_q    <= FP_PSTART;
			discard_q <= 1'b0;
			midx_q    <= '0;
			mok_q     <= 1'b1;
			acc_q     <= '0;
			neg_q     <= 1'b0;
			clen_q    <= '0;
			remain_q  <= '0;
			sticky_q  <= 1'b0;
		end else if (advance) begin
			if (pe) begin
				// packet done: restart at a first line
				phase_q   <= PH_FIRST;
				fpos_q    <= FP_PSTART;
				discard_q <= 1'b0;
				midx_q    <= '0;
				mok_q     <= 1'b1;
				acc_q     <= '0;
				neg_q     <= 1'b0;
				clen_q    <= '0;
				remain_q  <= '0;
				sticky_q  <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				fpos_q    <= fpos_n;
				discard_q <= discard_n;
				midx_q    <= midx_n;
				mok_q     <= mok_n;
				acc_q     <= acc_n;
				neg_q     <= neg_n;
				clen_q    <= clen_n;
				remain_q  <= remain_n;
				sticky_q  <= sticky_n;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			echo_byte   <= c;
			token_kind  <= kind;
			token_start <= start;
			error_code  <= err;
			error_seen  <= sticky_n;
			line_end    <= le;
			packet_end  <= pe;
			body_length <= clen_n;
		end
	end

	// ---------------- assertions ----------------
	a_body_remain_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> ((remain_q != '0) && (remain_q <= clen_q)))
		else $error("body phase with bad remaining count");

	a_error_sets_seen : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (error_code != ERR_NONE)) |-> error_seen)
		else $error("error reported without sticky flag");

	a_start_has_kind : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && token_start) |-> (token_kind != KIND_DELIM))
		else $error("token start on a delimiter byte");

	a_packet_end_restarts : assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pe) |=> ((phase_q == PH_FIRST) && !sticky_q && (clen_q == '0)))
		else $error("state not restarted after packet end");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for text_packet_header_parser
// Feeds a byte stream (a short directed table, then random packets with
// good and broken lines) through the valid/ready channels, predicts every
// tagged result beat and compares it field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
	import tphp_pkg::*;

	localparam int LEN_BITS    = 32;
	localparam int ITEMS       = 1300;  // random stream stops growing here
	localparam int PHASE_LEN   = 325;   // beats per idling phase
	localparam int HOLD_AT     = 120;   // result count that starts the long hold-off
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 3000;  // cycles with no beat on either side
	localparam int SETTLE      = 8;     // leave margin after the drain

	// lower-case header key that selects the body length
	localparam logic [111:0] LEN_KEY = "content-length";

	// One result beat, as the block should tag it.
	typedef struct packed {
		logic [7:0]  echo;
		kind_t       kind;
		logic        first;
		err_t        err;
		logic        sticky;
		logic        lend;
		logic        pend;
		logic [31:0] blen;
	} byte_tag_t;

	// One stimulus byte; 'typed' rows carry their result written out by hand.
	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		byte_tag_t  want;
	} stim_row_t;

	// Directed opening: empty first line, NUL as a bad protocol start, the
	// discarded rest of that line, a good first line, a mixed-case length
	// header, the blank line and a raw two-byte body (CR and 0xFF).
	localparam stim_row_t INTRO [27] = '{
		'{CH_LF,    1'b1, '{CH_LF, KIND_DELIM, 1'b0, ERR_EMPTY_FIRST, 1'b1, 1'b1, 1'b0, 32'd0}},
		'{8'h00,    1'b1, '{8'h00, KIND_DELIM, 1'b0, ERR_PROTO_FIRST, 1'b1, 1'b0, 1'b0, 32'd0}},
		'{CH_LF,    1'b1, '{CH_LF, KIND_DELIM, 1'b0, ERR_NONE, 1'b1, 1'b1, 1'b0, 32'd0}},
		'{"P",      1'b0, '0},
		'{CH_SPACE, 1'b0, '0},
		'{"M",      1'b0, '0},
		'{CH_LF,    1'b0, '0},
		'{"c",      1'b0, '0},
		'{"O",      1'b0, '0},
		'{"n",      1'b0, '0},
		'{"T",      1'b0, '0},
		'{"e",      1'b0, '0},
		'{"N",      1'b0, '0},
		'{"t",      1'b0, '0},
		'{CH_DASH,  1'b0, '0},
		'{"L",      1'b0, '0},
		'{"e",      1'b0, '0},
		'{"N",      1'b0, '0},
		'{"g",      1'b0, '0},
		'{"T",      1'b0, '0},
		'{"h",      1'b0, '0},
		'{CH_COLON, 1'b0, '0},
		'{"2",      1'b0, '0},
		'{CH_LF,    1'b0, '0},
		'{CH_LF,    1'b0, '0},
		'{CH_CR,    1'b0, '0},
		'{8'hFF,    1'b1, '{8'hFF, KIND_BODY, 1'b0, ERR_NONE, 1'b1, 1'b0, 1'b1, 32'd2}}
	};

	// ------------------------------------------------------------------------
	// Clock, reset and DUT
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          data_byte = 8'h00;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [7:0]          echo_byte;
	logic [2:0]          token_kind;
	logic                token_start;
	logic [3:0]          error_code;
	logic                error_seen;
	logic                line_end;
	logic                packet_end;
	logic [LEN_BITS-1:0] body_length;

	text_packet_header_parser #(
		.LENGTH_BITS(LEN_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.echo_byte  (echo_byte),
		.token_kind (token_kind),
		.token_start(token_start),
		.error_code (error_code),
		.error_seen (error_seen),
		.line_end   (line_end),
		.packet_end (packet_end),
		.body_length(body_length)
	);

	// ------------------------------------------------------------------------
	// Parser shadow: same state as the block, advanced once per input beat
	// ------------------------------------------------------------------------
	phase_t      ps_phase;
	fpos_t       ps_pos;
	logic        ps_discard;
	logic [3:0]  ps_key_idx;
	logic        ps_key_alive;
	logic [31:0] ps_acc;
	logic        ps_neg;
	logic [31:0] ps_len;
	logic [31:0] ps_left;
	logic        ps_sticky;

	function automatic bit in_span(logic [7:0] c, logic [7:0] lo, logic [7:0] hi);
		return (c >= lo) && (c <= hi);
	endfunction

	// Decimal accumulate, clamped to the largest length the port can carry.
	function automatic logic [31:0] push_digit(logic [31:0] a, logic [7:0] c);
		logic [63:0] w;
		w = {32'd0, a} * 64'd10 + {56'd0, c - 8'h30};
		if (w > (64'd1 << LEN_BITS) - 64'd1)
			w = (64'd1 << LEN_BITS) - 64'd1;
		return w[31:0];
	endfunction

	task automatic line_reset();
		ps_pos       = (ps_phase == PH_FIRST) ? FP_PSTART : FP_NSTART;
		ps_discard   = 1'b0;
		ps_key_idx   = 4'd0;
		ps_key_alive = 1'b1;
		ps_acc       = 32'd0;
		ps_neg       = 1'b0;
	endtask

	task automatic packet_reset();
		ps_phase  = PH_FIRST;
		ps_len    = 32'd0;
		ps_left   = 32'd0;
		ps_sticky = 1'b0;
		line_reset();
	endtask

	// Case-insensitive walk along the length key; one miss kills the match.
	task automatic key_step(input logic [7:0] c);
		logic [7:0] lc;
		lc = in_span(c, "A", "Z") ? c + 8'd32 : c;
		if (ps_key_alive) begin
			if (ps_key_idx < KEY_LEN && lc == LEN_KEY[8 * (13 - ps_key_idx) +: 8])
				ps_key_idx = ps_key_idx + 4'd1;
			else
				ps_key_alive = 1'b0;
		end
	endtask

	// Tag one byte and advance the shadow state.
	task automatic tag_byte(input logic [7:0] c, output byte_tag_t t);
		logic up, low, dig, tok, val;
		up  = in_span(c, "A", "Z");
		low = in_span(c, "a", "z");
		dig = in_span(c, "0", "9");
		tok = up || dig || c == CH_UNDER;
		val = in_span(c, VAL_LO, VAL_HI - 8'd1);
		t = '0;
		t.echo = c;
		t.kind = KIND_DELIM;
		t.err  = ERR_NONE;

		if (ps_phase == PH_BODY) begin
			// raw body: count down, flag the first and the last byte
			t.kind  = KIND_BODY;
			t.first = (ps_left == ps_len);
			if (ps_left > 0)
				ps_left = ps_left - 32'd1;
			if (ps_left == 0)
				t.pend = 1'b1;
		end else if (c == CH_CR) begin
			// drop CR outside the body
		end else if (c == CH_LF) begin
			t.lend = 1'b1;
			if (!ps_discard) begin
				if (ps_phase == PH_FIRST) begin
					case (ps_pos)
						FP_PREST:  t.err = ERR_PROTO_CHAR;
						FP_MSTART: t.err = ERR_METHOD_FIRST;
						FP_MREST:  ps_phase = PH_HEAD;
						default:   t.err = ERR_EMPTY_FIRST;
					endcase
				end else begin
					case (ps_pos)
						FP_NSTART: begin
							// blank line closes the headers
							if (ps_len > 0) begin
								ps_phase = PH_BODY;
								ps_left  = ps_len;
							end else begin
								t.pend = 1'b1;
							end
						end
						FP_NREST: t.err = ERR_NAME_CHAR;
						FP_SKIP:  t.err = ERR_NO_VALUE;
						FP_VDIG, FP_VTAIL: begin
							if (ps_key_alive) begin
								if (ps_len > 0)
									t.err = ERR_LEN_REPEAT;
								else if (ps_neg || ps_acc == 0)
									t.err = ERR_LEN_NONPOS;
								else
									ps_len = ps_acc;
							end
						end
						default: ;
					endcase
				end
			end
			if (!t.pend && ps_phase != PH_BODY)
				line_reset();
		end else if (!ps_discard) begin
			case (ps_pos)
				FP_PSTART: begin
					if (up) begin
						t.kind  = KIND_PROTO;
						t.first = 1'b1;
						ps_pos  = FP_PREST;
					end else begin
						t.err = ERR_PROTO_FIRST;
					end
				end
				FP_PREST: begin
					if (c == CH_SPACE)
						ps_pos = FP_MSTART;
					else if (tok)
						t.kind = KIND_PROTO;
					else
						t.err = ERR_PROTO_CHAR;
				end
				FP_MSTART: begin
					if (up) begin
						t.kind  = KIND_METHOD;
						t.first = 1'b1;
						ps_pos  = FP_MREST;
					end else begin
						t.err = ERR_METHOD_FIRST;
					end
				end
				FP_MREST: begin
					if (tok)
						t.kind = KIND_METHOD;
					else
						t.err = ERR_METHOD_CHAR;
				end
				FP_NSTART: begin
					if (up || low) begin
						t.kind  = KIND_NAME;
						t.first = 1'b1;
						key_step(c);
						ps_pos  = FP_NREST;
					end else begin
						t.err = ERR_NAME_FIRST;
					end
				end
				FP_NREST: begin
					if (c == CH_COLON) begin
						// the whole key must have matched, not just a prefix
						ps_key_alive = ps_key_alive && ps_key_idx == KEY_LEN;
						ps_pos       = FP_SKIP;
					end else if (up || low || dig || c == CH_UNDER || c == CH_DASH) begin
						t.kind = KIND_NAME;
						key_step(c);
					end else begin
						t.err = ERR_NAME_CHAR;
					end
				end
				FP_SKIP: begin
					if (c == CH_SPACE) begin
						// skip spaces ahead of the value
					end else if (!val) begin
						t.err = ERR_VALUE_CHAR;
					end else begin
						t.kind  = KIND_VALUE;
						t.first = 1'b1;
						ps_pos  = FP_VDIG;
						if (c == CH_DASH)
							ps_neg = 1'b1;
						else if (c == CH_PLUS)
							ps_neg = ps_neg;
						else if (dig)
							ps_acc = push_digit(ps_acc, c);
						else
							ps_pos = FP_VTAIL;
					end
				end
				FP_VDIG, FP_VTAIL: begin
					if (!val) begin
						t.err = ERR_VALUE_CHAR;
					end else begin
						t.kind = KIND_VALUE;
						if (ps_pos == FP_VDIG && dig)
							ps_acc = push_digit(ps_acc, c);
						else
							ps_pos = FP_VTAIL;
					end
				end
				default: ;
			endcase
			if (t.err != ERR_NONE)
				ps_discard = 1'b1;
		end

		if (t.err != ERR_NONE)
			ps_sticky = 1'b1;
		t.sticky = ps_sticky;
		t.blen   = ps_len;
		if (t.pend)
			packet_reset();
	endtask

	// ------------------------------------------------------------------------
	// Stream generator: mostly well-formed packets with random content, plus
	// corrupted lines, truncated lines and the odd burst of noise.
	// ------------------------------------------------------------------------
	stim_row_t   stim_q[$];
	logic [7:0]  line_buf[$];
	int unsigned want_len;  // body length the generator expects to be taken

	task automatic put(input logic [7:0] b);
		stim_row_t r;
		r = '0;
		r.b = b;
		stim_q.push_back(r);
	endtask

	// Never valid inside a token, a name or a value, and never LF or CR.
	function automatic logic [7:0] junk_byte();
		case ($urandom_range(0, 3))
			0:       return 8'($urandom_range(0, 9));
			1:       return 8'($urandom_range(14, 31));
			2:       return 8'($urandom_range(126, 255));
			default: return 8'($urandom_range(11, 12));
		endcase
	endfunction

	function automatic logic [7:0] tok_char();
		case ($urandom_range(0, 3))
			0:       return 8'($urandom_range(48, 57));
			1:       return CH_UNDER;
			default: return 8'($urandom_range(65, 90));
		endcase
	endfunction

	function automatic logic [7:0] name_char();
		case ($urandom_range(0, 5))
			0:       return 8'($urandom_range(65, 90));
			1:       return 8'($urandom_range(48, 57));
			2:       return CH_UNDER;
			3:       return CH_DASH;
			default: return 8'($urandom_range(97, 122));
		endcase
	endfunction

	task automatic put_token();
		line_buf.push_back(8'($urandom_range(65, 90)));
		repeat ($urandom_range(0, 4))
			line_buf.push_back(tok_char());
	endtask

	// Emit the buffered line, maybe with one byte spoiled, then CR? LF.
	task automatic close_line(input int spoil_pct, output bit spoiled);
		spoiled = 1'b0;
		if (line_buf.size() > 0 && $urandom_range(0, 99) < spoil_pct) begin
			line_buf[$urandom_range(0, line_buf.size() - 1)] = junk_byte();
			spoiled = 1'b1;
		end
		foreach (line_buf[i])
			put(line_buf[i]);
		if ($urandom_range(0, 3) == 0)
			put(CH_CR);
		put(CH_LF);
		line_buf.delete();
	endtask

	task automatic gen_first_line(output bit good);
		int  mode;
		bit  spoiled;
		mode = $urandom_range(0, 99);
		line_buf.delete();
		if (mode >= 4) begin
			put_token();
			if (mode >= 8) begin
				line_buf.push_back(CH_SPACE);
				if (mode >= 12)
					put_token();
			end
		end
		close_line(10, spoiled);
		good = (mode >= 12) && !spoiled;
	endtask

	task automatic gen_header();
		bit          is_len, len_ok, spoiled;
		int unsigned num;
		logic [7:0]  ch;
		string       digits;
		is_len = ($urandom_range(0, 99) < 30);
		len_ok = 1'b0;
		num    = 0;
		line_buf.delete();
		if (is_len) begin
			for (int i = 0; i < 14; i++) begin
				ch = LEN_KEY[8 * (13 - i) +: 8];
				if (in_span(ch, "a", "z") && $urandom_range(0, 1))
					ch = ch - 8'd32;
				line_buf.push_back(ch);
			end
		end else begin
			line_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(65, 90))
				: 8'($urandom_range(97, 122)));
			repeat ($urandom_range(0, 5))
				line_buf.push_back(name_char());
		end
		// now and then cut the line before the colon
		if ($urandom_range(0, 99) < 5) begin
			close_line(10, spoiled);
			return;
		end
		line_buf.push_back(CH_COLON);
		repeat ($urandom_range(0, 2))
			line_buf.push_back(CH_SPACE);
		if (is_len) begin
			case ($urandom_range(0, 9))
				0: line_buf.push_back("0");
				1: begin
					line_buf.push_back(CH_DASH);
					line_buf.push_back(8'($urandom_range(49, 57)));
				end
				2: line_buf.push_back(CH_PLUS);
				3: ;  // no value at all
				4: line_buf.push_back("x");
				default: begin
					if ($urandom_range(0, 3) == 0)
						line_buf.push_back(CH_PLUS);
					if ($urandom_range(0, 4) == 0)
						line_buf.push_back("0");
					num = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
						: $urandom_range(1, 8);
					digits = $sformatf("%0d", num);
					for (int i = 0; i < digits.len(); i++)
						line_buf.push_back(digits[i]);
					if ($urandom_range(0, 4) == 0) begin
						line_buf.push_back(CH_SPACE);
						line_buf.push_back("k");
					end
					len_ok = 1'b1;
				end
			endcase
		end else begin
			repeat ($urandom_range(0, 8))
				line_buf.push_back(8'($urandom_range(32, 125)));
		end
		close_line(8, spoiled);
		if (is_len && len_ok && !spoiled && want_len == 0)
			want_len = num;
	endtask

	task automatic gen_packet();
		bit good;
		want_len = 0;
		// noise line ahead of the packet
		if ($urandom_range(0, 99) < 5) begin
			repeat ($urandom_range(1, 6))
				put($urandom_range(0, 1) ? 8'($urandom_range(0, 9))
					: 8'($urandom_range(11, 255)));
			put(CH_LF);
		end
		do
			gen_first_line(good);
		while (!good);
		repeat ($urandom_range(0, 3))
			gen_header();
		if ($urandom_range(0, 1))
			put(CH_CR);
		put(CH_LF);
		repeat (want_len)
			put(8'($urandom_range(0, 255)));
	endtask

	// Last packet: a length that saturates, so the body runs past the end.
	task automatic gen_saturating_packet();
		string digits;
		digits = "A9 Q_1";
		for (int i = 0; i < digits.len(); i++)
			put(digits[i]);
		put(CH_LF);
		for (int i = 0; i < 14; i++)
			put(($urandom_range(0, 1) && i != 7) ? LEN_KEY[8 * (13 - i) +: 8] - 8'd32
				: LEN_KEY[8 * (13 - i) +: 8]);
		put(CH_COLON);
		put(CH_SPACE);
		digits = "99999999999";
		for (int i = 0; i < digits.len(); i++)
			put(digits[i]);
		put(CH_CR);
		put(CH_LF);
		put(CH_LF);
		repeat (6)
			put(8'($urandom_range(0, 255)));
	endtask

	// ------------------------------------------------------------------------
	// Idling phases, chosen by how many input beats have gone in
	// ------------------------------------------------------------------------
	int sent = 0;  // input beats accepted
	int got = 0;   // result beats accepted
	int send_idle, recv_stall;

	always @* begin
		case (sent / PHASE_LEN)
			0:       begin send_idle = 0;  recv_stall = 0;  end
			1:       begin send_idle = 60; recv_stall = 0;  end
			2:       begin send_idle = 0;  recv_stall = 60; end
			default: begin send_idle = 36; recv_stall = 36; end
		endcase
	end

	// Sender: hold valid and payload until the beat is taken, then offer
	// the next byte unless this cycle idles.
	int feed_idx = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (feed_idx < stim_q.size() && $urandom_range(0, 99) >= send_idle) begin
				in_valid  <= 1'b1;
				data_byte <= stim_q[feed_idx].b;
				feed_idx  = feed_idx + 1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off early in the run while
	// the sender keeps going, so both internal registers fill and in_ready
	// drops.
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && got >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	// ------------------------------------------------------------------------
	// Scoreboard: predict on every input beat, compare on every result beat
	// ------------------------------------------------------------------------
	byte_tag_t tags_due[$];
	int        mismatches = 0;

	task automatic check_field(input string fld, input logic [31:0] want,
			input logic [31:0] seen_v);
		if (seen_v !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, fld, want,
				seen_v);
		end
	endtask

	always @(posedge clk) begin : score
		byte_tag_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				tag_byte(data_byte, want);
				// hand-written rows override the shadow's answer
				if (stim_q[sent].typed)
					want = stim_q[sent].want;
				tags_due.push_back(want);
				sent <= sent + 1;
			end
			if (out_valid && out_ready) begin
				if (tags_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat, expected none actual %0h",
						$time, echo_byte);
				end else begin
					want = tags_due.pop_front();
					check_field("echo_byte", 32'(want.echo), 32'(echo_byte));
					check_field("token_kind", 32'(want.kind), 32'(token_kind));
					check_field("token_start", 32'(want.first), 32'(token_start));
					check_field("error_code", 32'(want.err), 32'(error_code));
					check_field("error_seen", 32'(want.sticky), 32'(error_seen));
					check_field("line_end", 32'(want.lend), 32'(line_end));
					check_field("packet_end", 32'(want.pend), 32'(packet_end));
					check_field("body_length", want.blen, 32'(body_length));
				end
				got <= got + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: stop the run when neither side moves for too long
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : run
		foreach (INTRO[i])
			stim_q.push_back(INTRO[i]);
		while (stim_q.size() < ITEMS)
			gen_packet();
		gen_saturating_packet();
		packet_reset();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// drain: every byte in, every tag out, then let the pipe settle
		while (sent != stim_q.size() || tags_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0 && tags_due.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
